// ===== hw/rtl/integer_field_formatter_core_assert.svh =====
// assertion macros for the integer field formatter checker
// expects clk and arst_n in the scope where they are used
`ifndef INTEGER_FIELD_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication
`define IFC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IFC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/ifc_pkg.sv =====
// shared types, constants and helpers of the integer field formatter
// no dependencies
`default_nettype none

package ifc_pkg;

	localparam int VAL_W     = 64;
	localparam int PREC_MAX  = 40;
	localparam int RADIX_MIN = 2;
	localparam int RADIX_MAX = 16;

	// format flag bit positions
	localparam int FLAG_SIGNED  = 0;
	localparam int FLAG_LEFT    = 1;
	localparam int FLAG_PLUS    = 2;
	localparam int FLAG_SPACE   = 3;
	localparam int FLAG_ZEROPAD = 4;
	localparam int FLAG_PREFIX  = 5;
	localparam int FLAG_LOWER   = 6;

	typedef logic [7:0] char_t;

	localparam char_t CH_NUL    = 8'h00;
	localparam char_t CH_ZERO   = 8'h30;
	localparam char_t CH_X      = 8'h58;
	localparam char_t CH_SPACE  = 8'h20;
	localparam char_t CH_MINUS  = 8'h2d;
	localparam char_t CH_PLUS   = 8'h2b;
	localparam char_t CASE_MASK = 8'h20;

	localparam char_t DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	typedef enum logic [1:0] {
		SGN_NONE,
		SGN_MINUS,
		SGN_PLUS,
		SGN_SPACE
	} sgn_t;

	// classified request, front to back
	typedef struct packed {
		logic [VAL_W-1:0] mag;
		logic [4:0]       radix;
		sgn_t             sgn;
		logic             left;
		logic             zeropad;
		logic             prefix;
		logic             lower;
		logic             zero_val;
		logic             dot;
		logic [5:0]       width;
		logic [5:0]       prec;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_WAIT,
		ST_SETUP,
		ST_EMIT
	} st_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_LEAD,
		PH_SIGN,
		PH_PFX,
		PH_MID,
		PH_ZFILL,
		PH_DIG,
		PH_TRAIL
	} ph_t;

	function automatic char_t digit_char(logic [3:0] d, logic lower);
		return DIGIT_CHARS[d] | (lower ? CASE_MASK : CH_NUL);
	endfunction

	function automatic char_t sign_char(sgn_t s);
		char_t c;
		c = CH_NUL;
		case (s)
			SGN_MINUS: c = CH_MINUS;
			SGN_PLUS:  c = CH_PLUS;
			SGN_SPACE: c = CH_SPACE;
			default:   c = CH_NUL;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ifc_front.sv =====
// front end: takes a request and classifies it into a command
// depends on ifc_pkg
`default_nettype none

module ifc_front import ifc_pkg::*; #(
	parameter int MAX_FIELD = 48
) (
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [63:0] value,
	input  logic [4:0]        radix,
	input  logic [6:0]        format_flags,
	input  logic [5:0]        total_width,
	input  logic [5:0]        min_digits,
	input  logic              precision_given,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output cmd_t              cmd
);

	localparam logic [6:0] MF = 7'(MAX_FIELD);
	localparam logic [5:0] PM = 6'(PREC_MAX);

	logic neg;
	logic left;

	always_comb begin
		neg  = format_flags[FLAG_SIGNED] && value[63];
		left = format_flags[FLAG_LEFT];
		cmd  = '0;

		cmd.mag = neg ? (64'd0 - $unsigned(value)) : $unsigned(value);

		if (radix < 5'(RADIX_MIN)) begin
			cmd.radix = 5'(RADIX_MIN);
		end else if (radix > 5'(RADIX_MAX)) begin
			cmd.radix = 5'(RADIX_MAX);
		end else begin
			cmd.radix = radix;
		end

		if (!format_flags[FLAG_SIGNED]) begin
			cmd.sgn = SGN_NONE;
		end else if (neg) begin
			cmd.sgn = SGN_MINUS;
		end else if (format_flags[FLAG_PLUS]) begin
			cmd.sgn = SGN_PLUS;
		end else if (format_flags[FLAG_SPACE]) begin
			cmd.sgn = SGN_SPACE;
		end else begin
			cmd.sgn = SGN_NONE;
		end

		cmd.left     = left;
		cmd.zeropad  = format_flags[FLAG_ZEROPAD] && !left;
		cmd.prefix   = format_flags[FLAG_PREFIX];
		cmd.lower    = format_flags[FLAG_LOWER];
		cmd.zero_val = (value == 64'sd0);
		cmd.dot      = precision_given;
		cmd.width    = ({1'b0, total_width} > MF) ? MF[5:0] : total_width;
		cmd.prec     = (min_digits > PM) ? PM : min_digits;
	end

	assign cmd_valid = in_valid;
	assign in_ready  = cmd_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/ifc_queue.sv =====
// two-entry command queue between front and back
// depends on ifc_pkg
`default_nettype none

module ifc_queue import ifc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int DEPTH = 2;

	cmd_t       mem_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign push_ready = (cnt_q != 2'(DEPTH));
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ifc_div.sv =====
// iterative divider of a 64-bit value by a small radix, 8 quotient bits a cycle
// no dependencies
`default_nettype none

module ifc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [4:0]  divisor,
	output logic        done,
	output logic [63:0] quotient,
	output logic [3:0]  remainder
);

	localparam int BITS  = 8;
	localparam int NSTEP = 64 / BITS;
	localparam int CNT_W = $clog2(NSTEP);

	logic [63:0]      acc_q;
	logic [3:0]       rem_q;
	logic [4:0]       div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [3:0]       r;
	logic [4:0]       t;
	logic [BITS-1:0]  qb;

	always_comb begin
		r  = rem_q;
		t  = '0;
		qb = '0;
		for (int i = 0; i < BITS; i++) begin
			t = {r, acc_q[63-i]};
			if (t >= div_q) begin
				r           = 4'(t - div_q);
				qb[BITS-1-i] = 1'b1;
			end else begin
				r = t[3:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NSTEP - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= 4'd0;
			div_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[63-BITS:0], qb};
			rem_q <= r;
		end
	end

	assign done      = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ifc_back.sv =====
// back end: digit extraction sequencer, digit stack and character emitter
// depends on ifc_pkg, drives ifc_div through its ports
`default_nettype none

module ifc_back import ifc_pkg::*; #(
	parameter int MAX_FIELD   = 48,
	parameter int DIGIT_DEPTH = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        div_start,
	output logic [63:0] div_dividend,
	output logic [4:0]  div_divisor,
	input  logic        div_done,
	input  logic [63:0] div_quotient,
	input  logic [3:0]  div_remainder,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_char,
	output logic        char_valid,
	output logic        last_char
);

	localparam int LEN_W = $clog2(3 + PREC_MAX + DIGIT_DEPTH + 1);
	localparam int DC_W  = $clog2(DIGIT_DEPTH + 1);

	typedef logic [LEN_W-1:0] len_t;

	st_t             st_q, st_d;
	ph_t             ph_q, ph_nx;
	len_t            rem_q, len_nx;
	len_t            cnt_q, tot_q;
	len_t            lead_q, mid_q, trail_q, zf_q;
	logic            pfx_on_q;
	cmd_t            cmd_q;
	logic [63:0]     mag_q;
	logic [DC_W-1:0] dc_q;
	logic [3:0]      dig_q [DIGIT_DEPTH];

	logic            out_valid_q;
	char_t           out_char_q;
	logic            char_valid_q;
	logic            last_char_q;

	logic            cmd_take;
	logic            zero_digit;
	logic            slot_free;
	logic            last_digit;
	logic            dig_push;
	logic            dig_pop;
	logic [3:0]      push_val;
	logic            emit_now;
	logic            emit_last;
	char_t           emit_char;

	len_t            sgn_len, pfx_len, prec_e, dc_e, p_len, fixed_len;
	len_t            wid_e, tot_len, pad_len, tot_eff;
	logic            pfx_on;

	assign cmd_ready  = (st_q == ST_IDLE);
	assign cmd_take   = cmd_ready && cmd_valid;
	assign zero_digit = (cmd.mag == 64'd0) && ((cmd.prec != 6'd0) || !cmd.dot);
	assign slot_free  = !out_valid_q || out_ready;
	assign last_digit = (dc_q == DC_W'(DIGIT_DEPTH - 1));
	assign emit_last  = (cnt_q == tot_q - len_t'(1));

	assign div_dividend = mag_q;
	assign div_divisor  = cmd_q.radix;

	// field layout
	always_comb begin
		sgn_len   = len_t'(cmd_q.sgn != SGN_NONE);
		pfx_on    = cmd_q.prefix && !(cmd_q.zero_val && cmd_q.left);
		pfx_len   = pfx_on ? len_t'(2) : len_t'(0);
		prec_e    = len_t'(cmd_q.prec);
		dc_e      = len_t'(dc_q);
		p_len     = (prec_e > dc_e) ? prec_e : dc_e;
		fixed_len = sgn_len + pfx_len + p_len;
		wid_e     = len_t'(cmd_q.width);
		tot_len   = (wid_e > fixed_len) ? wid_e : fixed_len;
		pad_len   = tot_len - fixed_len;
		tot_eff   = (tot_len > len_t'(MAX_FIELD)) ? len_t'(MAX_FIELD) : tot_len;
	end

	// phase order and lengths
	always_comb begin
		case (ph_q)
			PH_START: ph_nx = PH_LEAD;
			PH_LEAD:  ph_nx = PH_SIGN;
			PH_SIGN:  ph_nx = PH_PFX;
			PH_PFX:   ph_nx = PH_MID;
			PH_MID:   ph_nx = PH_ZFILL;
			PH_ZFILL: ph_nx = PH_DIG;
			PH_DIG:   ph_nx = PH_TRAIL;
			default:  ph_nx = PH_TRAIL;
		endcase
		case (ph_nx)
			PH_LEAD:  len_nx = lead_q;
			PH_SIGN:  len_nx = len_t'(cmd_q.sgn != SGN_NONE);
			PH_PFX:   len_nx = pfx_on_q ? len_t'(2) : len_t'(0);
			PH_MID:   len_nx = mid_q;
			PH_ZFILL: len_nx = zf_q;
			PH_DIG:   len_nx = len_t'(dc_q);
			PH_TRAIL: len_nx = trail_q;
			default:  len_nx = len_t'(0);
		endcase
	end

	// character of the current phase
	always_comb begin
		case (ph_q)
			PH_LEAD:  emit_char = CH_SPACE;
			PH_SIGN:  emit_char = sign_char(cmd_q.sgn);
			PH_PFX: begin
				if (cmd_q.zero_val) begin
					emit_char = CH_SPACE;
				end else if (rem_q == len_t'(2)) begin
					emit_char = CH_ZERO;
				end else begin
					emit_char = CH_X | (cmd_q.lower ? CASE_MASK : CH_NUL);
				end
			end
			PH_MID:   emit_char = CH_ZERO;
			PH_ZFILL: emit_char = CH_ZERO;
			PH_DIG:   emit_char = digit_char(dig_q[0], cmd_q.lower);
			PH_TRAIL: emit_char = CH_SPACE;
			default:  emit_char = CH_NUL;
		endcase
		if (tot_q == len_t'(0)) emit_char = CH_NUL;
	end

	// sequencer next state and strobes
	always_comb begin
		st_d      = st_q;
		div_start = 1'b0;
		emit_now  = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid) st_d = (cmd.mag == 64'd0) ? ST_SETUP : ST_DIV;
			end
			ST_DIV: begin
				div_start = 1'b1;
				st_d      = ST_WAIT;
			end
			ST_WAIT: begin
				if (div_done) begin
					st_d = ((div_quotient == 64'd0) || last_digit) ? ST_SETUP : ST_DIV;
				end
			end
			ST_SETUP: st_d = ST_EMIT;
			ST_EMIT: begin
				if (tot_q == len_t'(0)) begin
					if (slot_free) begin
						emit_now = 1'b1;
						st_d     = ST_IDLE;
					end
				end else if ((rem_q != len_t'(0)) && slot_free) begin
					emit_now = 1'b1;
					if (emit_last) st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign dig_push = (cmd_take && zero_digit) || ((st_q == ST_WAIT) && div_done);
	assign dig_pop  = emit_now && (ph_q == PH_DIG) && (tot_q != len_t'(0));
	assign push_val = cmd_take ? 4'd0 : div_remainder;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ph_q        <= PH_START;
			rem_q       <= '0;
			cnt_q       <= '0;
			dc_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd_take) begin
				dc_q <= zero_digit ? DC_W'(1) : DC_W'(0);
			end else if ((st_q == ST_WAIT) && div_done) begin
				dc_q <= dc_q + DC_W'(1);
			end
			if (st_q == ST_SETUP) begin
				ph_q  <= PH_START;
				rem_q <= '0;
				cnt_q <= '0;
			end else if (st_q == ST_EMIT) begin
				if (rem_q == len_t'(0)) begin
					ph_q  <= ph_nx;
					rem_q <= len_nx;
				end else if (emit_now) begin
					rem_q <= rem_q - len_t'(1);
					cnt_q <= cnt_q + len_t'(1);
				end
			end
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
			mag_q <= cmd.mag;
		end else if ((st_q == ST_WAIT) && div_done) begin
			mag_q <= div_quotient;
		end

		// digit stack, top at entry zero
		if (dig_push) begin
			dig_q[0] <= push_val;
			for (int i = 1; i < DIGIT_DEPTH; i++) dig_q[i] <= dig_q[i-1];
		end else if (dig_pop) begin
			for (int i = 0; i < DIGIT_DEPTH - 1; i++) dig_q[i] <= dig_q[i+1];
		end

		if (st_q == ST_SETUP) begin
			lead_q   <= (!cmd_q.zeropad && !cmd_q.left) ? pad_len : len_t'(0);
			mid_q    <= cmd_q.zeropad ? pad_len : len_t'(0);
			trail_q  <= cmd_q.left ? pad_len : len_t'(0);
			zf_q     <= p_len - dc_e;
			pfx_on_q <= pfx_on;
			tot_q    <= tot_eff;
		end

		if (emit_now) begin
			out_char_q   <= emit_char;
			char_valid_q <= (tot_q != len_t'(0));
			last_char_q  <= (tot_q == len_t'(0)) || emit_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign char_valid = char_valid_q;
	assign last_char  = last_char_q;

endmodule

`default_nettype wire

// ===== hw/rtl/integer_field_formatter_core.sv =====
// integer field formatter: turns one conversion request into an ASCII field
// usage:
//   input channel (in_valid/in_ready) takes one transaction per request: value,
//   radix, format_flags, total_width, min_digits, precision_given
//   output channel (out_valid/out_ready) gives one character per transaction,
//   last_char marks the end of a request; an empty field gives a single
//   transaction with char_valid low and last_char high
// processing:
//   digits come from an iterative divider, one division of 8 divide steps plus
//   start and collect per digit; divided digits are capped at DIGIT_DEPTH, none
//   for a zero value, and the field is capped at MAX_FIELD characters;
//   requests are processed one at a time by the back end
//   a two-entry queue takes up to two more requests while one is in progress
// reset: arst_n clears the queue, the divider, the sequencer and the output valid flag
// stall: with out_ready low the current character is held and the back end
//   waits; the queue then fills and in_ready drops
// depends on ifc_pkg, ifc_front, ifc_queue, ifc_div, ifc_back
`default_nettype none

module integer_field_formatter_core import ifc_pkg::*; #(
	parameter int MAX_FIELD   = 48,
	parameter int DIGIT_DEPTH = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [63:0] value,
	input  logic [4:0]         radix,
	input  logic [6:0]         format_flags,
	input  logic [5:0]         total_width,
	input  logic [5:0]         min_digits,
	input  logic               precision_given,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_char,
	output logic               char_valid,
	output logic               last_char
);

	cmd_t        front_cmd;
	logic        front_valid;
	logic        front_ready;
	cmd_t        back_cmd;
	logic        back_valid;
	logic        back_ready;
	logic        div_start;
	logic [63:0] div_dividend;
	logic [4:0]  div_divisor;
	logic        div_done;
	logic [63:0] div_quotient;
	logic [3:0]  div_remainder;

	ifc_front #(
		.MAX_FIELD (MAX_FIELD)
	) u_front (
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.value           (value),
		.radix           (radix),
		.format_flags    (format_flags),
		.total_width     (total_width),
		.min_digits      (min_digits),
		.precision_given (precision_given),
		.cmd_valid       (front_valid),
		.cmd_ready       (front_ready),
		.cmd             (front_cmd)
	);

	ifc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	ifc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quotient),
		.remainder (div_remainder)
	);

	ifc_back #(
		.MAX_FIELD   (MAX_FIELD),
		.DIGIT_DEPTH (DIGIT_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (back_valid),
		.cmd_ready     (back_ready),
		.cmd           (back_cmd),
		.div_start     (div_start),
		.div_dividend  (div_dividend),
		.div_divisor   (div_divisor),
		.div_done      (div_done),
		.div_quotient  (div_quotient),
		.div_remainder (div_remainder),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_char      (out_char),
		.char_valid    (char_valid),
		.last_char     (last_char)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/ifc_chk.sv =====
// port-level checker of the integer field formatter, bound to the top level
// depends on integer_field_formatter_core_assert.svh
`default_nettype none

`include "integer_field_formatter_core_assert.svh"

module ifc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       char_valid,
	input logic       last_char
);

	// stalled transaction holds
	`IFC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(char_valid) && $stable(last_char), "output changed under stall")

	// empty field is one null transaction
	`IFC_ASSERT_IMP(a_empty_form, out_valid && !char_valid, last_char && (out_char == 8'h00), "bad empty-field transaction")

	// field characters are printable
	`IFC_ASSERT_IMP(a_printable, out_valid && char_valid, (out_char >= 8'h20) && (out_char <= 8'h7a), "character out of range")

	// inside a field no empty marker may appear
	`IFC_ASSERT_NXT(a_no_empty_mid, out_valid && out_ready && !last_char, !(out_valid && !char_valid), "empty marker inside a field")

endmodule

bind integer_field_formatter_core ifc_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.out_char   (out_char),
	.char_valid (char_valid),
	.last_char  (last_char)
);

`default_nettype wire
